[design/wdstk_pkg.sv]
// Shared constants, types and helper functions of the weighted dot score top-k unit.
`timescale 1ns / 1ps
package wdstk_pkg;

  localparam int VECTOR_LENGTH = 256;
  localparam int FACTOR_COUNT  = 4;
  localparam int KEEP_DEPTH    = 16;

  localparam int ADDR_W  = $clog2(FACTOR_COUNT * VECTOR_LENGTH);
  localparam int CNT_W   = $clog2(KEEP_DEPTH + 1);
  localparam int SCORE_W = 40;
  localparam int ACC_W   = 48;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SCORE = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [2:0] REG_CONTEXT_WEIGHT = 3'd0;
  localparam logic [2:0] REG_TOP_SIZE       = 3'd1;
  localparam logic [2:0] REG_FACTOR_WEIGHT0 = 3'd2;
  localparam logic [2:0] REG_FACTOR_WEIGHT1 = 3'd3;
  localparam logic [2:0] REG_FACTOR_WEIGHT2 = 3'd4;
  localparam logic [2:0] REG_FACTOR_WEIGHT3 = 3'd5;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [15:0]               shard;
    logic [63:0]               document;
  } entry_t;

  // What a cell shows its neighbors: its entry and how it compares to the new score.
  typedef struct packed {
    entry_t entry;
    logic   ge;  // empty, or holds a score above the new one
    logic   le;  // holds a score at or below the new one
  } link_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REPLACE,
    OP_DRAIN
  } op_e;

  // Saturate a 49 bit sum into the 48 bit accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] x);
    if (x[ACC_W] != x[ACC_W-1]) begin
      sat_acc = x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_acc = x[ACC_W-1:0];
    end
  endfunction

endpackage

[design/weighted_dot_score_top_k_unit.sv]
// Top level of the weighted dot score top-k unit: query store, scoring datapath, keep chain.
//
// Usage: a command beat is taken at a clock edge with start_i high and busy_o low.
// A load command writes one query element and leaves busy_o low, so a new command
// may follow in the next cycle. A score command runs a fixed sequence: query read,
// multiply, accumulate; an element that ends a factor adds blend, scale and
// score update; an element that ends a reply adds the sorted insert into the
// keep chain. The query read and the multiply, blend and scale are registered
// stages, and busy_o stays high until the sequence ends.
// A drain command emits one kept entry per cycle in ascending score order, each
// beat on the result ports for one cycle with valid_o high, last_out_o on the final
// beat; an empty set emits nothing. The receiver cannot stall the block.
// Configuration beats on cfg_valid_i/cfg_ready_o are taken at any time; write
// them only while the block is idle.
// Reset clears the accumulators, the kept count and the registers to their
// defaults; the query store holds garbage until loaded.
`timescale 1ns / 1ps
module weighted_dot_score_top_k_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      cmd_i,
  input  logic [1:0]                      factor_i,
  input  logic [7:0]                      index_i,
  input  logic signed [15:0]              query_value_i,
  input  logic signed [15:0]              context_value_i,
  input  logic signed [15:0]              reply_value_i,
  input  logic                            end_of_factor_i,
  input  logic                            end_of_reply_i,
  input  logic [15:0]                     shard_number_i,
  input  logic [63:0]                     document_number_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [16:0]                     cfg_data_i,
  output logic                            valid_o,
  output logic signed [39:0]              score_out_o,
  output logic [15:0]                     shard_out_o,
  output logic [63:0]                     document_out_o,
  output logic                            last_out_o
);
  import wdstk_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_ACC   = 8'b0000_0100,
    S_BLEND = 8'b0000_1000,
    S_SCALE = 8'b0001_0000,
    S_SCORE = 8'b0010_0000,
    S_KEEP  = 8'b0100_0000,
    S_DRAIN = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Configuration registers.
  logic [16:0]        cw_q;
  logic [4:0]         top_q;
  logic signed [15:0] fw_q [FACTOR_COUNT];

  // Latched command.
  logic               eof_q, eor_q, in_range_q;
  logic [1:0]         factor_q;
  logic signed [15:0] cv_q, rv_q;
  logic [15:0]        shard_q;
  logic [63:0]        doc_q;

  logic [15:0]             mem [FACTOR_COUNT * VECTOR_LENGTH];
  logic signed [15:0]      rd_q;
  logic [ADDR_W-1:0]       addr;
  logic                    in_range;

  logic signed [31:0]      pc_prod_q, pr_prod_q;
  logic signed [ACC_W-1:0] cacc_q, racc_q;
  logic signed [51:0]      bc_q, br_q;
  logic signed [52:0]      dp_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [CNT_W-1:0]        count_q;

  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  assign in_range = (32'(factor_i) < FACTOR_COUNT) && (32'(index_i) < VECTOR_LENGTH);
  assign addr     = ADDR_W'(32'(factor_i) * VECTOR_LENGTH + 32'(index_i));

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CMD_LOAD && in_range) begin
      mem[addr] <= query_value_i;
    end
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q  <= 17'd32768;
      top_q <= 5'd10;
      for (int i = 0; i < FACTOR_COUNT; i++) begin
        fw_q[i] <= (i == 0) ? 16'sd4096 : 16'sd0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i) inside
        REG_CONTEXT_WEIGHT: cw_q  <= cfg_data_i;
        REG_TOP_SIZE:       top_q <= cfg_data_i[4:0];
        [REG_FACTOR_WEIGHT0:REG_FACTOR_WEIGHT3]: begin
          if (32'(cfg_index_i - REG_FACTOR_WEIGHT0) < FACTOR_COUNT) begin
            fw_q[2'(cfg_index_i - REG_FACTOR_WEIGHT0)] <= cfg_data_i[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      eof_q      <= end_of_factor_i;
      eor_q      <= end_of_reply_i;
      in_range_q <= in_range;
      factor_q   <= factor_i;
      cv_q       <= context_value_i;
      rv_q       <= reply_value_i;
      shard_q    <= shard_number_i;
      doc_q      <= document_number_i;
    end
  end

  // Effective weights, limit and keep decision.
  logic [16:0]        w_eff;
  logic [16:0]        w_rest;
  logic signed [15:0] fw_eff;
  logic signed [15:0] q_eff;
  logic [CNT_W-1:0]   limit;
  logic               do_insert, do_replace;

  assign w_eff  = (cw_q > 17'd65536) ? 17'd65536 : cw_q;
  assign w_rest = 17'd65536 - w_eff;
  assign fw_eff = (32'(factor_q) < FACTOR_COUNT) ? fw_q[factor_q] : 16'sd0;
  assign q_eff  = in_range_q ? rd_q : 16'sd0;

  always_comb begin
    if (top_q == 5'd0) begin
      limit = CNT_W'(1);
    end else if (32'(top_q) > KEEP_DEPTH) begin
      limit = CNT_W'(KEEP_DEPTH);
    end else begin
      limit = CNT_W'(top_q);
    end
  end

  link_t  links [KEEP_DEPTH];
  logic   cell_valid [KEEP_DEPTH];
  op_e    op;
  entry_t new_entry;

  assign new_entry.score    = score_q;
  assign new_entry.shard    = shard_q;
  assign new_entry.document = doc_q;

  assign do_insert  = (count_q < limit);
  assign do_replace = !do_insert && (count_q != '0) && links[0].le
                      && (links[0].entry.score != score_q);

  always_comb begin
    op = OP_HOLD;
    if (state_q == S_KEEP) begin
      if (do_insert) begin
        op = OP_INSERT;
      end else if (do_replace) begin
        op = OP_REPLACE;
      end
    end else if (state_q == S_DRAIN) begin
      op = OP_DRAIN;
    end
  end

  for (genvar g = 0; g < KEEP_DEPTH; g++) begin : g_cell
    link_t prev_l, next_l;
    assign cell_valid[g] = (32'(count_q) > g);
    if (g == 0) begin : g_first
      assign prev_l = '0;
    end else begin : g_mid
      assign prev_l = links[g-1];
    end
    if (g == KEEP_DEPTH - 1) begin : g_last
      assign next_l = '0;
    end else begin : g_inner
      assign next_l = links[g+1];
    end
    wdstk_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .valid_i (cell_valid[g]),
      .new_i   (new_entry),
      .prev_i  (prev_l),
      .next_i  (next_l),
      .link_o  (links[g])
    );
  end

  // Datapath arithmetic.
  logic signed [ACC_W:0]   csum, rsum, cr, rr;
  logic signed [52:0]      bsum;
  logic signed [36:0]      blend;
  logic signed [52:0]      dsum;
  logic signed [40:0]      delta;
  logic signed [41:0]      ssum;
  logic signed [SCORE_W-1:0] score_sat;

  assign csum  = $signed({cacc_q[ACC_W-1], cacc_q}) + $signed({{17{pc_prod_q[31]}}, pc_prod_q});
  assign rsum  = $signed({racc_q[ACC_W-1], racc_q}) + $signed({{17{pr_prod_q[31]}}, pr_prod_q});
  assign cr    = $signed({cacc_q[ACC_W-1], cacc_q}) + $signed((ACC_W+1)'(1 << 14));
  assign rr    = $signed({racc_q[ACC_W-1], racc_q}) + $signed((ACC_W+1)'(1 << 14));
  assign bsum  = $signed({bc_q[51], bc_q}) + $signed({br_q[51], br_q}) + $signed(53'(1 << 15));
  assign blend = bsum[52:16];
  assign dsum  = dp_q + $signed(53'(1 << 11));
  assign delta = dsum[52:12];
  assign ssum  = $signed({{2{score_q[SCORE_W-1]}}, score_q}) + $signed({delta[40], delta});

  always_comb begin
    if (ssum[41:39] != 3'b000 && ssum[41:39] != 3'b111) begin
      score_sat = ssum[41] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      score_sat = ssum[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    pc_prod_q <= q_eff * cv_q;
    pr_prod_q <= q_eff * rv_q;
    bc_q      <= $signed(cr[ACC_W:15]) * $signed({1'b0, w_eff});
    br_q      <= $signed(rr[ACC_W:15]) * $signed({1'b0, w_rest});
    dp_q      <= blend * fw_eff;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd_i == CMD_SCORE) begin
          state_d = S_MUL;
        end else if (accept && cmd_i == CMD_DRAIN && count_q != '0) begin
          state_d = S_DRAIN;
        end
      end
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = eof_q ? S_BLEND : (eor_q ? S_KEEP : S_IDLE);
      S_BLEND: state_d = S_SCALE;
      S_SCALE: state_d = S_SCORE;
      S_SCORE: state_d = eor_q ? S_KEEP : S_IDLE;
      S_KEEP:  state_d = S_IDLE;
      S_DRAIN: state_d = (count_q == CNT_W'(1)) ? S_IDLE : S_DRAIN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cacc_q  <= '0;
      racc_q  <= '0;
      score_q <= '0;
      count_q <= '0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= (state_q == S_DRAIN);
      if (state_q == S_ACC) begin
        cacc_q <= sat_acc(csum);
        racc_q <= sat_acc(rsum);
      end
      if (state_q == S_BLEND || state_q == S_KEEP) begin
        cacc_q <= '0;
        racc_q <= '0;
      end
      if (state_q == S_SCORE) begin
        score_q <= score_sat;
      end
      if (state_q == S_KEEP) begin
        score_q <= '0;
        if (do_insert) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (state_q == S_DRAIN) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DRAIN) begin
      score_out_o    <= links[0].entry.score;
      shard_out_o    <= links[0].entry.shard;
      document_out_o <= links[0].entry.document;
      last_out_o     <= (count_q == CNT_W'(1));
    end
  end

`ifndef SYNTH
  a_idle_no_strobe_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_SCORE) |=> !valid_o)
    else $error("result beat during a score command");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= KEEP_DEPTH)
    else $error("kept count beyond the chain depth");

  a_drain_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("drain beat without count decrement");

  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_out_o) |-> (count_q == '0 && !busy_o))
    else $error("last beat while entries remain");
`endif

endmodule

[design/wdstk_cell.sv]
// One cell of the sorted keep chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps
module wdstk_cell (
  input  logic                   clk_i,
  input  wdstk_pkg::op_e         op_i,
  input  logic                   valid_i,
  input  wdstk_pkg::entry_t      new_i,
  input  wdstk_pkg::link_t       prev_i,
  input  wdstk_pkg::link_t       next_i,
  output wdstk_pkg::link_t       link_o
);
  import wdstk_pkg::*;

  entry_t entry_q, entry_d;
  logic   gt;

  assign gt           = valid_i && (entry_q.score > new_i.score);
  assign link_o.entry = entry_q;
  assign link_o.ge    = gt || !valid_i;
  assign link_o.le    = valid_i && !gt;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      OP_INSERT: begin
        // Entries above the insertion point move up by one place.
        if (prev_i.ge) begin
          entry_d = prev_i.entry;
        end else if (link_o.ge) begin
          entry_d = new_i;
        end
      end
      OP_REPLACE: begin
        // The minimum falls out; entries at or below the new score move down.
        if (next_i.le) begin
          entry_d = next_i.entry;
        end else if (link_o.le) begin
          entry_d = new_i;
        end
      end
      OP_DRAIN: begin
        entry_d = next_i.entry;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[test/testbench.sv]
// Self-checking testbench of the weighted dot score top-k unit with a scoring predictor.
`timescale 1ns / 1ps
module testbench;
  import wdstk_pkg::*;

  typedef struct {
    logic signed [39:0] score;
    logic [15:0]        shard;
    logic [63:0]        document;
    logic               last;
  } kept_beat_t;

  class score_board;
    logic [15:0]  query_mem [FACTOR_COUNT*VECTOR_LENGTH];
    longint       ctx_dot, reply_dot, reply_score;
    longint       best_score [KEEP_DEPTH];
    logic [15:0]  best_shard [KEEP_DEPTH];
    logic [63:0]  best_doc [KEEP_DEPTH];
    int           best_count;
    logic [16:0]  ctx_weight;
    logic [4:0]   keep_size;
    logic [15:0]  factor_wt [4];
    kept_beat_t   drain_q [$];
    int           errors;
    int           beats_seen;

    function new();
      ctx_dot = 0; reply_dot = 0; reply_score = 0; best_count = 0;
      ctx_weight = 17'd32768; keep_size = 5'd10;
      factor_wt[0] = 16'd4096; factor_wt[1] = 0; factor_wt[2] = 0; factor_wt[3] = 0;
      errors = 0; beats_seen = 0;
    endfunction

    function void report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function longint round_sh(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function void set_reg(logic [2:0] idx, logic [16:0] data);
      case (idx)
        REG_CONTEXT_WEIGHT: ctx_weight = data;
        REG_TOP_SIZE:       keep_size = data[4:0];
        REG_FACTOR_WEIGHT0: factor_wt[0] = data[15:0];
        REG_FACTOR_WEIGHT1: factor_wt[1] = data[15:0];
        REG_FACTOR_WEIGHT2: factor_wt[2] = data[15:0];
        REG_FACTOR_WEIGHT3: factor_wt[3] = data[15:0];
        default: ;
      endcase
    endfunction

    function void insert_best(longint sc, logic [15:0] sh, logic [63:0] doc);
      int pos;
      pos = best_count;
      while (pos > 0 && best_score[pos-1] > sc) begin
        best_score[pos] = best_score[pos-1];
        best_shard[pos] = best_shard[pos-1];
        best_doc[pos] = best_doc[pos-1];
        pos--;
      end
      best_score[pos] = sc; best_shard[pos] = sh; best_doc[pos] = doc;
      best_count++;
    endfunction

    function void keep_reply(longint sc, logic [15:0] sh, logic [63:0] doc);
      int lim;
      lim = keep_size;
      if (lim < 1) lim = 1;
      if (lim > KEEP_DEPTH) lim = KEEP_DEPTH;
      if (best_count < lim) begin
        insert_best(sc, sh, doc);
      end else if (best_count > 0 && sc > best_score[0]) begin
        // The minimum leaves even when the set is larger than the current size.
        for (int i = 1; i < best_count; i++) begin
          best_score[i-1] = best_score[i];
          best_shard[i-1] = best_shard[i];
          best_doc[i-1] = best_doc[i];
        end
        best_count--;
        insert_best(sc, sh, doc);
      end
    endfunction

    function void note_input(logic [1:0] cmd, logic [1:0] factor, logic [7:0] index,
                             logic [15:0] qv, logic [15:0] cv, logic [15:0] rv,
                             logic eof, logic eor, logic [15:0] shard, logic [63:0] doc);
      int     addr;
      longint q, w, dc, dr, blend, fw;
      kept_beat_t b;
      addr = int'(factor) * VECTOR_LENGTH + int'(index);
      if (cmd == CMD_LOAD) begin
        query_mem[addr] = qv;
      end else if (cmd == CMD_SCORE) begin
        q = longint'($signed(query_mem[addr]));
        ctx_dot = clamp(ctx_dot + q * longint'($signed(cv)), -(longint'(1) << 47),
                        (longint'(1) << 47) - 1);
        reply_dot = clamp(reply_dot + q * longint'($signed(rv)), -(longint'(1) << 47),
                          (longint'(1) << 47) - 1);
        if (eof) begin
          w = ctx_weight > 17'd65536 ? 65536 : longint'(ctx_weight);
          dc = round_sh(ctx_dot, 15);
          dr = round_sh(reply_dot, 15);
          blend = round_sh(dc * w + dr * (65536 - w), 16);
          fw = longint'($signed(factor_wt[factor]));
          reply_score = clamp(reply_score + round_sh(blend * fw, 12),
                              -(longint'(1) << 39), (longint'(1) << 39) - 1);
          ctx_dot = 0; reply_dot = 0;
        end
        if (eor) begin
          keep_reply(reply_score, shard, doc);
          reply_score = 0; ctx_dot = 0; reply_dot = 0;
        end
      end else if (cmd == CMD_DRAIN) begin
        for (int k = 0; k < best_count; k++) begin
          b.score = best_score[k][39:0];
          b.shard = best_shard[k];
          b.document = best_doc[k];
          b.last = (k + 1 == best_count);
          drain_q = {drain_q, b};
        end
        best_count = 0;
      end
    endfunction

    function void check_result(logic [39:0] score, logic [15:0] shard, logic [63:0] doc,
                               logic last);
      kept_beat_t b;
      beats_seen++;
      if (drain_q.size() == 0) begin
        report_mismatch($sformatf("unexpected drain beat score %0d", $signed(score)));
        return;
      end
      b = drain_q.pop_front();
      if (score !== b.score)
        report_mismatch($sformatf("score %0d, expected %0d", $signed(score), b.score));
      if (shard !== b.shard)
        report_mismatch($sformatf("shard %h, expected %h", shard, b.shard));
      if (doc !== b.document)
        report_mismatch($sformatf("document %h, expected %h", doc, b.document));
      if (last !== b.last)
        report_mismatch($sformatf("last %b, expected %b", last, b.last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i, busy_o;
  logic [1:0] cmd_i, factor_i;
  logic [7:0] index_i;
  logic signed [15:0] query_value_i, context_value_i, reply_value_i;
  logic end_of_factor_i, end_of_reply_i;
  logic [15:0] shard_number_i;
  logic [63:0] document_number_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [16:0] cfg_data_i;
  logic valid_o, last_out_o;
  logic signed [39:0] score_out_o;
  logic [15:0] shard_out_o;
  logic [63:0] document_out_o;

  score_board sb;
  int  cycle_count = 0;
  int  item_count = 0;
  int  setting_count = 0;
  bit  idle_en = 1'b1;
  int  loaded_idx [4][$];

  always #4 clk_i = ~clk_i;

  weighted_dot_score_top_k_unit u_dut (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      sb.note_input(cmd_i, factor_i, index_i, query_value_i, context_value_i, reply_value_i,
                    end_of_factor_i, end_of_reply_i, shard_number_i, document_number_i);
    if (rst_ni && valid_o)
      sb.check_result(score_out_o, shard_out_o, document_out_o, last_out_o);
  end

  task automatic send(logic [1:0] cmd, logic [1:0] f, logic [7:0] idx, logic [15:0] qv,
                      logic [15:0] cv, logic [15:0] rv, logic eof, logic eor,
                      logic [15:0] sh, logic [63:0] doc);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= cmd; factor_i <= f; index_i <= idx;
    query_value_i <= qv; context_value_i <= cv; reply_value_i <= rv;
    end_of_factor_i <= eof; end_of_reply_i <= eor;
    shard_number_i <= sh; document_number_i <= doc;
    do @(posedge clk_i); while (busy_o);
    item_count++;
    if (cmd == CMD_LOAD && f < FACTOR_COUNT) loaded_idx[f] = {loaded_idx[f], int'(idx)};
  endtask

  // Holds the sender off until every drain beat is back and the datapath has settled.
  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.drain_q.size() != 0 || busy_o);
    repeat (10) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller drops it after the last beat of a sequence.
  task automatic write_reg(logic [2:0] idx, logic [16:0] data);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic write_setting(logic [16:0] cw, logic [4:0] ts, logic [15:0] w0,
                               logic [15:0] w1, logic [15:0] w2, logic [15:0] w3);
    write_reg(REG_CONTEXT_WEIGHT, cw);
    write_reg(REG_TOP_SIZE, {12'd0, ts});
    write_reg(REG_FACTOR_WEIGHT0, {1'b0, w0});
    write_reg(REG_FACTOR_WEIGHT1, {1'b0, w1});
    write_reg(REG_FACTOR_WEIGHT2, {1'b0, w2});
    write_reg(REG_FACTOR_WEIGHT3, {1'b0, w3});
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_idx(int f);
    return 8'(loaded_idx[f][$urandom_range(0, loaded_idx[f].size() - 1)]);
  endfunction

  task automatic send_reply();
    int nf, len, f;
    bit cut;
    logic [15:0] sh;
    logic [63:0] doc;
    nf = $urandom_range(1, 4);
    cut = ($urandom_range(0, 9) == 0);
    sh = 16'($urandom);
    doc = {$urandom, $urandom};
    for (int i = 0; i < nf; i++) begin
      f = $urandom_range(0, 3);
      len = $urandom_range(1, 4);
      for (int e = 0; e < len; e++) begin
        // A cut reply ends on an element that does not close its factor.
        if (cut && i == nf - 1 && e == len - 1)
          send(CMD_SCORE, 2'(f), pick_idx(f), 16'($urandom), rand_val(), rand_val(),
               1'b0, 1'b1, sh, doc);
        else
          send(CMD_SCORE, 2'(f), pick_idx(f), 16'($urandom), rand_val(), rand_val(),
               e == len - 1, i == nf - 1 && e == len - 1, sh, doc);
      end
    end
  endtask

  task automatic run_phase(int n);
    int stop;
    stop = item_count + n;
    while (item_count < stop) begin
      case ($urandom_range(0, 19))
        0, 1:  send(CMD_LOAD, 2'($urandom), 8'($urandom), rand_val(), 16'($urandom),
                    16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                    {$urandom, $urandom});
        2:     send(2'd3, 2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                    {$urandom, $urandom});
        3, 4:  send(CMD_DRAIN, 2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                    {$urandom, $urandom});
        default: send_reply();
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst_ni <= 1'b0;
    start_i <= 1'b0; cmd_i <= CMD_LOAD; factor_i <= 0; index_i <= 0;
    query_value_i <= 0; context_value_i <= 0; reply_value_i <= 0;
    end_of_factor_i <= 0; end_of_reply_i <= 0; shard_number_i <= 0;
    document_number_i <= 0; cfg_valid_i <= 0; cfg_index_i <= REG_CONTEXT_WEIGHT;
    cfg_data_i <= 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part at reset settings: extremes, ignored fields, unknown command, empty drain.
    for (int f = 0; f < 4; f++) begin
      send(CMD_LOAD, 2'(f), 8'd0, f[0] ? 16'h8000 : 16'h7FFF, 0, 0, 0, 0, 0, 0);
      send(CMD_LOAD, 2'(f), 8'd255, f[0] ? 16'h7FFF : 16'h8000, 0, 0, 0, 0, 0, 0);
    end
    send(CMD_LOAD, 2'd2, 8'd1, 16'h1234, 16'hFFFF, 16'hFFFF, 1, 1, 16'hFFFF, '1);
    send(2'd3, 2'd3, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 16'hFFFF, '1);
    send(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_SCORE, 2'd0, 8'd0, 0, 16'h7FFF, 16'h8000, 1, 0, 0, 0);
    send(CMD_SCORE, 2'd1, 8'd255, 0, 16'h8000, 16'h8000, 1, 1, 16'hFFFF, '1);
    send(CMD_SCORE, 2'd0, 8'd255, 0, 16'h8000, 16'h7FFF, 1, 1, 16'h0000, 64'd0);
    send(CMD_SCORE, 2'd0, 8'd0, 0, 16'h7FFF, 16'h7FFF, 0, 1, 16'h00AA, 64'd5);
    send(CMD_SCORE, 2'd0, 8'd0, 0, 16'h7FFF, 16'h7FFF, 0, 1, 16'h00BB, 64'd6);
    send(CMD_SCORE, 2'd2, 8'd1, 0, 16'h7FFF, 16'h0001, 1, 1, 16'h5555, 64'd7);
    send(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    write_setting(17'd65536, 5'd16, 16'h7FFF, 16'h8000, 16'd4096, 16'hF000);
    run_phase(90);
    wait_idle();
    // The set is not drained here, so under the smaller size below a better reply replaces the minimum.
    write_setting(17'd0, 5'd1, 16'h8000, 16'h7FFF, 16'd1, 16'd0);
    run_phase(90);
    send(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();
    write_setting(17'h1FFFF, 5'd0, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    run_phase(90);
    send(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();
    write_setting(17'($urandom_range(0, 65536)), 5'd31, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    run_phase(90);
    wait_idle();
    write_setting(17'($urandom_range(0, 65536)), 5'($urandom_range(1, 16)), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    idle_en = 1'b0;
    run_phase(90);
    send(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (sb.drain_q.size() != 0)
      sb.report_mismatch($sformatf("%0d drain beats never arrived", sb.drain_q.size()));
    $display("Run covered %0d commands and %0d drained entries over %0d register settings.",
             item_count, sb.beats_seen, setting_count);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
